/* design/b2db_pkg.sv */
// Shared constants, control record and array types for the binary to blanked decimal converter.
package b2db_pkg;

    localparam int VALUE_W        = 32;
    localparam int CNT_W          = 8;
    localparam int CHAR_W         = 6;
    localparam int NUM_CHARS      = 7;
    localparam int DIGIT_W        = 4;
    localparam int MAX_DIGITS_DEF = 7;
    localparam int DD_STEPS       = 8;
    localparam int DD_STAGES      = VALUE_W / DD_STEPS;
    localparam int S_TDATA_W      = ((VALUE_W + 2 * CNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W      = ((NUM_CHARS * CHAR_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 6'd32;

    typedef struct packed {
        logic [CNT_W-1:0] digit_count;
        logic [CNT_W-1:0] blank_count;
    } b2db_ctl_t;

    typedef logic [NUM_CHARS-1:0][DIGIT_W-1:0] b2db_digits_t;
    typedef logic [NUM_CHARS-1:0][CHAR_W-1:0]  b2db_chars_t;

endpackage

/* design/b2db_dabble.sv */
// One double dabble pipeline stage that shifts a fixed number of binary bits into the BCD word.
module b2db_dabble
    import b2db_pkg::*;
#(
    parameter int N_DIG = MAX_DIGITS_DEF,
    parameter int STEPS = DD_STEPS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [VALUE_W-1:0]         in_bin,
    input  logic [DIGIT_W*N_DIG-1:0]   in_bcd,
    input  b2db_ctl_t                  in_ctl,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [VALUE_W-1:0]         out_bin,
    output logic [DIGIT_W*N_DIG-1:0]   out_bcd,
    output b2db_ctl_t                  out_ctl
);

    localparam int BCD_W = DIGIT_W * N_DIG;

    logic                 vld_reg;
    logic [VALUE_W-1:0]   bin_reg;
    logic [VALUE_W-1:0]   bin_next;
    logic [BCD_W-1:0]     bcd_reg;
    logic [BCD_W-1:0]     bcd_next;
    b2db_ctl_t            ctl_reg;

    assign in_ready = !vld_reg || out_ready;

    // Each step adds three to every digit of five or more, then shifts one bit in.
    // The carry out of the top digit is dropped, which keeps the value modulo 10^N_DIG.
    always_comb
    begin
        bcd_next = in_bcd;
        bin_next = in_bin;
        for (int s = 0; s < STEPS; s++)
        begin
            for (int d = 0; d < N_DIG; d++)
            begin
                if (bcd_next[d*DIGIT_W +: DIGIT_W] >= 4'd5)
                begin
                    bcd_next[d*DIGIT_W +: DIGIT_W] = bcd_next[d*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            {bcd_next, bin_next} = {bcd_next[BCD_W-2:0], bin_next, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
            ctl_reg <= in_ctl;
        end
    end

    assign out_valid = vld_reg;
    assign out_bin   = bin_reg;
    assign out_bcd   = bcd_reg;
    assign out_ctl   = ctl_reg;

endmodule

/* design/b2db_select.sv */
// Stage that places the wanted BCD digits on the character positions and marks which may blank.
module b2db_select
    import b2db_pkg::*;
#(
    parameter int N_DIG = MAX_DIGITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [DIGIT_W*N_DIG-1:0]   in_bcd,
    input  b2db_ctl_t                  in_ctl,
    output logic                       out_valid,
    input  logic                       out_ready,
    output b2db_digits_t               out_dig,
    output logic [NUM_CHARS-1:0]       out_ok
);

    logic                  vld_reg;
    logic                  count_ok;
    b2db_digits_t          dig_reg;
    b2db_digits_t          dig_next;
    logic [NUM_CHARS-1:0]  ok_reg;
    logic [NUM_CHARS-1:0]  ok_next;

    assign in_ready = !vld_reg || out_ready;
    assign count_ok = (in_ctl.digit_count != '0) &&
                      (in_ctl.digit_count <= CNT_W'(N_DIG));

    // Position k shows digit (count - 1 - k) counted from the units digit.
    always_comb
    begin
        for (int k = 0; k < NUM_CHARS; k++)
        begin
            dig_next[k] = '0;
            if (count_ok)
            begin
                for (int j = 0; j < N_DIG; j++)
                begin
                    if (CNT_W'(j + k + 1) == in_ctl.digit_count)
                    begin
                        dig_next[k] = in_bcd[j*DIGIT_W +: DIGIT_W];
                    end
                end
            end
            ok_next[k] = count_ok && (CNT_W'(k + 1) < in_ctl.digit_count) &&
                         (CNT_W'(k) < in_ctl.blank_count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            dig_reg <= dig_next;
            ok_reg  <= ok_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_dig   = dig_reg;
    assign out_ok    = ok_reg;

endmodule

/* design/b2db_blank.sv */
// Output stage that blanks the leading zero run and forms the ASCII characters.
module b2db_blank
    import b2db_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  b2db_digits_t           in_dig,
    input  logic [NUM_CHARS-1:0]   in_ok,
    output logic                   out_valid,
    input  logic                   out_ready,
    output b2db_chars_t            out_char
);

    logic          vld_reg;
    logic          run;
    b2db_chars_t   char_reg;
    b2db_chars_t   char_next;

    assign in_ready = !vld_reg || out_ready;

    always_comb
    begin
        run = 1'b1;
        for (int k = 0; k < NUM_CHARS; k++)
        begin
            if (run && in_ok[k] && (in_dig[k] == '0))
            begin
                char_next[k] = CHAR_SPACE;
            end
            else
            begin
                run          = 1'b0;
                char_next[k] = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, in_dig[k]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= char_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_char  = char_reg;

endmodule

/* design/binary_to_decimal_blanked_top.sv */
// Top level of the pipelined binary to blanked ASCII decimal converter.
//
//  Channel   Direction  Width  Contents
//  s_*       in         48     value, digit_count, blank_count
//  m_*       out        48     char0 .. char6
//
// An item can enter every cycle while m_tready does not stall the pipe; its result passes through
// four double dabble stages of eight bits each, one digit select stage
// and one blanking stage that is also the output register.
// Reset clears only the valid bit of each stage.
// A stall on m_tready holds every full stage; nothing is lost or repeated.
module binary_to_decimal_blanked_top
    import b2db_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // value[31:0], digit_count[39:32], blank_count[47:40]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // char0[5:0], char1[11:6], char2[17:12], char3[23:18], char4[29:24],
    // char5[35:30], char6[41:36], zero fill above
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int BCD_W = DIGIT_W * MAX_DIGITS;

    logic                 dd_vld [DD_STAGES+1];
    logic                 dd_rdy [DD_STAGES+1];
    logic [VALUE_W-1:0]   dd_bin [DD_STAGES+1];
    logic [BCD_W-1:0]     dd_bcd [DD_STAGES+1];
    b2db_ctl_t            dd_ctl [DD_STAGES+1];

    logic                 sel_vld;
    logic                 sel_rdy;
    b2db_digits_t         sel_dig;
    logic [NUM_CHARS-1:0] sel_ok;
    b2db_chars_t          out_char;

    assign dd_vld[0]             = s_tvalid;
    assign s_tready              = dd_rdy[0];
    assign dd_bin[0]             = s_tdata[VALUE_W-1:0];
    assign dd_bcd[0]             = '0;
    assign dd_ctl[0].digit_count = s_tdata[VALUE_W +: CNT_W];
    assign dd_ctl[0].blank_count = s_tdata[VALUE_W+CNT_W +: CNT_W];

    for (genvar g = 0; g < DD_STAGES; g++)
    begin : g_dd
        b2db_dabble #(
            .N_DIG (MAX_DIGITS),
            .STEPS (DD_STEPS)
        ) u_dabble (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dd_vld[g]),
            .in_ready  (dd_rdy[g]),
            .in_bin    (dd_bin[g]),
            .in_bcd    (dd_bcd[g]),
            .in_ctl    (dd_ctl[g]),
            .out_valid (dd_vld[g+1]),
            .out_ready (dd_rdy[g+1]),
            .out_bin   (dd_bin[g+1]),
            .out_bcd   (dd_bcd[g+1]),
            .out_ctl   (dd_ctl[g+1])
        );
    end

    b2db_select #(
        .N_DIG (MAX_DIGITS)
    ) u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dd_vld[DD_STAGES]),
        .in_ready  (dd_rdy[DD_STAGES]),
        .in_bcd    (dd_bcd[DD_STAGES]),
        .in_ctl    (dd_ctl[DD_STAGES]),
        .out_valid (sel_vld),
        .out_ready (sel_rdy),
        .out_dig   (sel_dig),
        .out_ok    (sel_ok)
    );

    b2db_blank u_blank (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sel_vld),
        .in_ready  (sel_rdy),
        .in_dig    (sel_dig),
        .in_ok     (sel_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char)
    );

    always_comb
    begin
        m_tdata = '0;
        for (int k = 0; k < NUM_CHARS; k++)
        begin
            m_tdata[k*CHAR_W +: CHAR_W] = out_char[k];
        end
    end

    // An empty output stage lets every stage above it move, so the input is ready.
    a_empty_out_ready : assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input not ready while output stage is empty");

    a_accept_fills : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> dd_vld[1])
        else $error("accepted beat did not reach the first stage");

    a_blank_prefix : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2*CHAR_W-1:CHAR_W] == CHAR_SPACE) |->
        (m_tdata[CHAR_W-1:0] == CHAR_SPACE))
        else $error("blanked character follows a shown character");

endmodule

/* verif/binary_to_decimal_blanked_top_test.sv */
// Self-checking testbench for the binary to blanked ASCII decimal converter stream.
module binary_to_decimal_blanked_top_test
    import b2db_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DIRECTED = 23;
    localparam int NUM_RANDOM   = 1850;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int TEXT_W       = 8 * NUM_CHARS;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   digits;
        logic [CNT_W-1:0]   blanks;
        logic               typed;
        logic [TEXT_W-1:0]  text;
    } number_case_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    b2db_chars_t   pending_rows[$];
    number_case_t  directed_rows [NUM_DIRECTED];
    int            fault_count = 0;
    int            quiet_cycles = 0;
    bit            steady = 1'b0;

    binary_to_decimal_blanked_top #(
        .MAX_DIGITS(MAX_DIGITS_DEF)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic b2db_chars_t decimal_row(input logic [VALUE_W-1:0] value,
                                                input logic [CNT_W-1:0] digits,
                                                input logic [CNT_W-1:0] blanks);
        b2db_chars_t        row;
        logic [VALUE_W-1:0] rest;
        int                 pos;
        int                 left;
        for (pos = 0; pos < NUM_CHARS; pos++)
            row[pos] = CHAR_ZERO;
        if (digits >= 1 && digits <= MAX_DIGITS_DEF)
        begin
            rest = value;
            for (pos = int'(digits) - 1; pos >= 0; pos--)
            begin
                row[pos] = CHAR_ZERO + CHAR_W'(rest % 10);
                rest = rest / 10;
            end
            left = int'(blanks);
            pos = 0;
            while (pos + 1 < int'(digits) && row[pos] == CHAR_ZERO && left > 0)
            begin
                row[pos] = CHAR_SPACE;
                left--;
                pos++;
            end
        end
        return row;
    endfunction

    function automatic b2db_chars_t text_row(input logic [TEXT_W-1:0] text);
        b2db_chars_t row;
        for (int k = 0; k < NUM_CHARS; k++)
            row[k] = text[8 * (NUM_CHARS - 1 - k) +: CHAR_W];
        return row;
    endfunction

    task automatic drive_number(input logic [VALUE_W-1:0] value,
                                input logic [CNT_W-1:0] digits,
                                input logic [CNT_W-1:0] blanks,
                                input b2db_chars_t expected);
        while (!steady && $urandom_range(0, 99) < 9)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blanks, digits, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_rows.push_back(expected);
    endtask

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 9);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_rows.size() == 0)
            begin
                if (fault_count < 10)
                    $display("unexpected result beat %h", m_tdata);
                fault_count++;
            end
            else
            begin
                b2db_chars_t want;
                want = pending_rows.pop_front();
                for (int k = 0; k < NUM_CHARS; k++)
                begin
                    if (m_tdata[k * CHAR_W +: CHAR_W] !== want[k])
                    begin
                        if (fault_count < 10)
                            $display("char%0d mismatch: expected %0d, got %0d",
                                     k, want[k], m_tdata[k * CHAR_W +: CHAR_W]);
                        fault_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("binary_to_decimal_blanked_top_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] tens;
        logic [CNT_W-1:0]   digits;
        logic [CNT_W-1:0]   blanks;
        b2db_chars_t        want;

        directed_rows = '{
            '{32'd0,          8'd0,   8'd0,   1'b1, "0000000"},
            '{32'hFFFFFFFF,   8'd0,   8'd255, 1'b1, "0000000"},
            '{32'd12345,      8'd8,   8'd7,   1'b1, "0000000"},
            '{32'd0,          8'd255, 8'd255, 1'b1, "0000000"},
            '{32'd0,          8'd7,   8'd255, 1'b1, "      0"},
            '{32'hFFFFFFFF,   8'd7,   8'd0,   1'b1, "4967295"},
            '{32'hFFFFFFFF,   8'd7,   8'd255, 1'b1, "4967295"},
            '{32'd0,          8'd1,   8'd255, 1'b1, "0000000"},
            '{32'd9,          8'd1,   8'd0,   1'b1, "9000000"},
            '{32'd0,          8'd7,   8'd0,   1'b1, "0000000"},
            '{32'd42,         8'd7,   8'd3,   1'b0, 56'd0},
            '{32'd1000000,    8'd7,   8'd255, 1'b0, 56'd0},
            '{32'd12345678,   8'd7,   8'd2,   1'b0, 56'd0},
            '{32'd100,        8'd3,   8'd255, 1'b0, 56'd0},
            '{32'd1000,       8'd3,   8'd255, 1'b0, 56'd0},
            '{32'd5,          8'd4,   8'd1,   1'b0, 56'd0},
            '{32'd5,          8'd4,   8'd255, 1'b0, 56'd0},
            '{32'd0,          8'd2,   8'd1,   1'b0, 56'd0},
            '{32'h80000000,   8'd7,   8'd255, 1'b0, 56'd0},
            '{32'h55555555,   8'd6,   8'd128, 1'b0, 56'd0},
            '{32'hAAAAAAAA,   8'd5,   8'd64,  1'b0, 56'd0},
            '{32'd9999999,    8'd7,   8'd255, 1'b0, 56'd0},
            '{32'd10000000,   8'd7,   8'd255, 1'b0, 56'd0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].typed)
                want = text_row(directed_rows[i].text);
            else
                want = decimal_row(directed_rows[i].value, directed_rows[i].digits,
                                   directed_rows[i].blanks);
            drive_number(directed_rows[i].value, directed_rows[i].digits,
                         directed_rows[i].blanks, want);
        end

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            steady = (n >= 700 && n < 1100);
            if (n == 400)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_rows.size() != 0)
                    @(posedge clk);
            end
            case ($urandom_range(0, 3))
                0: value = $urandom();
                1: value = $urandom_range(0, 999);
                2:
                begin
                    tens = 1;
                    repeat ($urandom_range(0, 9)) tens = tens * 10;
                    value = tens * $urandom_range(0, 9);
                end
                default: value = $urandom_range(0, 9999999);
            endcase
            if ($urandom_range(0, 99) < 85)
                digits = CNT_W'($urandom_range(1, MAX_DIGITS_DEF));
            else
                digits = CNT_W'($urandom());
            if ($urandom_range(0, 99) < 70)
                blanks = CNT_W'($urandom_range(0, 8));
            else
                blanks = CNT_W'($urandom());
            drive_number(value, digits, blanks, decimal_row(value, digits, blanks));
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("binary_to_decimal_blanked_top_test: done, clean");
        else
            $display("binary_to_decimal_blanked_top_test: done, errors");
        $finish;
    end

endmodule

/* files.f */
design/b2db_pkg.sv
design/b2db_dabble.sv
design/b2db_select.sv
design/b2db_blank.sv
design/binary_to_decimal_blanked_top.sv
verif/binary_to_decimal_blanked_top_test.sv
